@@ src/pidb_pkg.sv @@
package pidb_pkg;

  // field widths
  localparam int DATA_WIDTH = 16;
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 15;
  localparam int FRAC_W     = 8;
  localparam int IDX_W      = 8;

  // datapath widths
  localparam int ERR_W   = DATA_WIDTH + 1;
  localparam int OP_W    = DATA_WIDTH + 2;
  localparam int PROD_W  = OP_W + GAIN_W;
  localparam int PD_W    = PROD_W + 1;
  localparam int INTEG_W = 40;
  localparam int SUM_W   = ((PD_W > INTEG_W) ? PD_W : INTEG_W) + 2;
  localparam int CNT_W   = $clog2(GAIN_W);

  // integral bleed, about 0.99 in Q0.16
  localparam int BLEED_W = 16;
  localparam logic [BLEED_W-1:0] BLEED_MUL = 16'd64881;

  localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

  // register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_KP          = 8'd0,
    REG_KI_DT       = 8'd1,
    REG_KD_PER_DT   = 8'd2,
    REG_DRIVE_LIMIT = 8'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_INTEG,
    ST_SUM,
    ST_CMP,
    ST_BLEED,
    ST_DONE
  } pidb_state_t;

  // control of one serial multiplier
  typedef struct packed {
    logic load;
    logic step;
  } ser_ctrl_t;

endpackage

@@ src/pidb_in_if.sv @@
interface pidb_in_if;
  import pidb_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] setpoint;
  logic signed [DATA_WIDTH-1:0] measurement;

  modport source (output valid, output setpoint, output measurement, input ready);
  modport sink (input valid, input setpoint, input measurement, output ready);
endinterface

@@ src/pidb_out_if.sv @@
interface pidb_out_if;
  import pidb_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] drive;
  logic                         saturated;

  modport source (output valid, output drive, output saturated, input ready);
  modport sink (input valid, input drive, input saturated, output ready);
endinterface

@@ src/pidb_cfg_if.sv @@
interface pidb_cfg_if;
  import pidb_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [31:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/pid_controller_with_integral_bleed_unit.sv @@
// PID regulator with integral bleed on output saturation.
// in_chan carries one control tick (setpoint, measurement); out_chan returns
// one result (drive, saturated) per tick; cfg_chan writes kp, ki_dt,
// kd_per_dt and the drive limit by index and is always ready. Writes must
// go in only while no tick is in flight; the block does not enforce this.
// The three gain products are formed by serial shift-add units, one gain
// bit per cycle, and the 0.99 bleed of the integral is another serial
// pass over the constant bits. One tick is in work at a time.
// The result sits in an output register; the next tick is accepted while
// it waits. If the receiver stalls, the following result holds in its last
// step until the output register frees.
// Synchronous reset restores the gains to their defaults (kp = 1.0,
// ki_dt = kd_per_dt = 0, limit 32767) and clears the integral and the
// previous error.
module pid_controller_with_integral_bleed_unit (
  input logic         clk,
  input logic         rst_n,
  pidb_in_if.sink     in_chan,
  pidb_out_if.source  out_chan,
  pidb_cfg_if.sink    cfg_chan
);
  import pidb_pkg::*;

  pidb_state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [GAIN_W-1:0]  kp_r, ki_r, kd_r;
  logic [LIMIT_W-1:0] lim_r;

  logic signed [ERR_W-1:0]   err_r, prev_err_r;
  logic signed [OP_W-1:0]    delta_r;
  logic signed [INTEG_W-1:0] integ_r;
  logic signed [PD_W-1:0]    pd_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic signed [INTEG_W-1:0] bleed_acc_r;
  logic [BLEED_W-1:0]        bleed_k_r;
  logic signed [DATA_WIDTH-1:0] drive_r, out_drive_r;
  logic sat_r, out_sat_r, out_valid_r;

  logic in_fire, out_load, cnt_last;
  logic signed [ERR_W-1:0]   err_c;
  logic signed [OP_W-1:0]    delta_c;
  logic signed [PROD_W-1:0]  p_prod, i_prod, d_prod;
  logic signed [INTEG_W:0]   integ_sum;
  logic signed [INTEG_W-1:0] integ_sat;
  logic signed [INTEG_W:0]   bleed_sum;
  logic signed [SUM_W-1:0]   lim_s, neg_lim_s;
  logic over_hi, over_lo;
  logic signed [DATA_WIDTH-1:0] lim_drive;
  ser_ctrl_t ser_ctrl;

  // configuration writes
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r  <= GAIN_W'(256);
      ki_r  <= '0;
      kd_r  <= '0;
      lim_r <= {LIMIT_W{1'b1}};
    end else if (cfg_chan.valid) begin
      unique case (reg_idx_t'(cfg_chan.index))
        REG_KP:          kp_r  <= cfg_chan.data[GAIN_W-1:0];
        REG_KI_DT:       ki_r  <= cfg_chan.data[GAIN_W-1:0];
        REG_KD_PER_DT:   kd_r  <= cfg_chan.data[GAIN_W-1:0];
        REG_DRIVE_LIMIT: lim_r <= cfg_chan.data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // request handshakes
  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign cnt_last      = (cnt_r == CNT_W'(GAIN_W - 1));

  // error and its change
  assign err_c   = ERR_W'(in_chan.setpoint) - ERR_W'(in_chan.measurement);
  assign delta_c = OP_W'(err_c) - OP_W'(prev_err_r);

  // serial gain multipliers
  assign ser_ctrl.load = in_fire;
  assign ser_ctrl.step = (state_r == ST_MUL);

  pidb_sermul u_mul_p (
    .clk(clk), .ctrl(ser_ctrl), .gain(kp_r), .operand(OP_W'(err_r)), .product(p_prod)
  );
  pidb_sermul u_mul_i (
    .clk(clk), .ctrl(ser_ctrl), .gain(ki_r), .operand(OP_W'(err_r)), .product(i_prod)
  );
  pidb_sermul u_mul_d (
    .clk(clk), .ctrl(ser_ctrl), .gain(kd_r), .operand(delta_r), .product(d_prod)
  );

  // integral update with saturation at its width
  assign integ_sum = (INTEG_W+1)'(integ_r) + (INTEG_W+1)'(i_prod);
  always_comb begin
    integ_sat = integ_sum[INTEG_W-1:0];
    if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
      integ_sat = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
    end
  end

  // limit compare in q.8 units
  assign lim_s     = $signed({{(SUM_W-LIMIT_W-FRAC_W){1'b0}}, lim_r, {FRAC_W{1'b0}}});
  assign neg_lim_s = -lim_s;
  assign over_hi   = (sum_r > lim_s);
  assign over_lo   = (sum_r < neg_lim_s);
  assign lim_drive = $signed(DATA_WIDTH'(lim_r));

  // lsb-first bleed step, low product bits fall off the bottom
  assign bleed_sum = (INTEG_W+1)'(bleed_acc_r) +
                     (bleed_k_r[0] ? (INTEG_W+1)'(integ_r) : '0);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_MUL;
          cnt_nxt   = '0;
        end
      end
      ST_MUL: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_last) begin
          state_nxt = ST_INTEG;
        end
      end
      ST_INTEG: state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_CMP;
      ST_CMP: begin
        cnt_nxt   = '0;
        state_nxt = (over_hi || over_lo) ? ST_BLEED : ST_DONE;
      end
      ST_BLEED: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // kept state: integral and previous error
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r    <= '0;
      prev_err_r <= '0;
    end else begin
      if (in_fire) begin
        prev_err_r <= err_c;
      end
      if (state_r == ST_INTEG) begin
        integ_r <= integ_sat;
      end else if (state_r == ST_BLEED && cnt_last) begin
        integ_r <= bleed_sum[INTEG_W:1];
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      err_r   <= err_c;
      delta_r <= delta_c;
    end
    if (state_r == ST_INTEG) begin
      pd_r <= PD_W'(p_prod) + PD_W'(d_prod);
    end
    if (state_r == ST_SUM) begin
      sum_r <= SUM_W'(pd_r) + SUM_W'(integ_r);
    end
    if (state_r == ST_CMP) begin
      bleed_acc_r <= '0;
      bleed_k_r   <= BLEED_MUL;
      sat_r       <= over_hi || over_lo;
      if (over_hi) begin
        drive_r <= lim_drive;
      end else if (over_lo) begin
        drive_r <= -lim_drive;
      end else begin
        drive_r <= sum_r[FRAC_W +: DATA_WIDTH];
      end
    end
    if (state_r == ST_BLEED) begin
      bleed_acc_r <= bleed_sum[INTEG_W:1];
      bleed_k_r   <= bleed_k_r >> 1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_drive_r <= drive_r;
      out_sat_r   <= sat_r;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.drive     = out_drive_r;
  assign out_chan.saturated = out_sat_r;

endmodule

@@ src/pidb_sermul.sv @@
module pidb_sermul (
  input  logic                                  clk,
  input  pidb_pkg::ser_ctrl_t                   ctrl,
  input  logic [pidb_pkg::GAIN_W-1:0]           gain,
  input  logic signed [pidb_pkg::OP_W-1:0]      operand,
  output logic signed [pidb_pkg::PROD_W-1:0]    product
);
  import pidb_pkg::*;

  logic [GAIN_W-1:0]        gain_r;
  logic signed [PROD_W-1:0] acc_r;
  logic signed [PROD_W-1:0] acc_nxt;

  // msb-first shift and add, one gain bit per cycle while step is high
  always_comb begin
    acc_nxt = acc_r <<< 1;
    if (gain_r[GAIN_W-1]) begin
      acc_nxt = acc_nxt + PROD_W'(operand);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      gain_r <= gain;
      acc_r  <= '0;
    end else if (ctrl.step) begin
      gain_r <= gain_r << 1;
      acc_r  <= acc_nxt;
    end
  end

  assign product = acc_r;

endmodule
